>>> hdl/gasu_pkg.sv
// ---------------------------------------------------------------------------
// gasu_pkg
// Shared constants, controller states and command/status bundles for the
// gradient averaging SGD update core.
// ---------------------------------------------------------------------------
package gasu_pkg;

    localparam int VLEN    = 512;             // elements per gradient vector
    localparam int ADDR_W  = $clog2(VLEN);
    localparam int ACC_W   = 40;              // accumulator word
    localparam int PAR_W   = 32;              // parameter word, Q8.24
    localparam int GRAD_W  = 32;              // gradient word, Q8.24
    localparam int LR_W    = 24;              // learning rate, Q0.24
    localparam int WC_W    = 7;               // worker_count register
    localparam int MIB_W   = 6;               // message-in-batch counter
    localparam int BATCH_W = 32;
    localparam int FRAC_W  = 24;
    localparam int SUM_W   = ACC_W + 1;       // acc + grad, signed
    localparam int MAG_W   = ACC_W;           // |sum| always fits here
    localparam int HALF_W  = MAG_W / 2;       // multiplier split point
    localparam int PP_W    = LR_W + HALF_W;   // partial product width
    localparam int PROD_W  = 64;              // full |lr * avg|
    localparam int NV_W    = PAR_W + 10;      // updated param before clamp

    localparam logic [WC_W-1:0] WC_RESET = WC_W'(4);
    localparam logic [WC_W-1:0] WC_MAX   = WC_W'(64);
    localparam logic [WC_W-1:0] WC_MIN   = WC_W'(1);

    localparam logic [PAR_W-1:0] PAR_MAX = {1'b0, {(PAR_W-1){1'b1}}};
    localparam logic [PAR_W-1:0] PAR_MIN = {1'b1, {(PAR_W-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DIV_START,
        ST_DIV,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ROUND,
        ST_SUB,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic capture;
        logic sum_load;
        logic div_start;
        logic mul_lo;
        logic mul_hi;
        logic round;
        logic sub;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic kind;
        logic is_final;
        logic div_done;
        logic clr_last;
    } t_status;

endpackage

>>> hdl/gasu_if.sv
// ---------------------------------------------------------------------------
// gasu_if
// Valid/ready channels for gradient/read words in and result words out.
// ---------------------------------------------------------------------------
interface gasu_in_if
    import gasu_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic signed [GRAD_W-1:0] grad_value;
    logic [LR_W-1:0]          step_rate;
    logic [ADDR_W-1:0]        read_index;

    modport source (
        output valid, kind, grad_value, step_rate, read_index,
        input  ready
    );
    modport sink (
        input  valid, kind, grad_value, step_rate, read_index,
        output ready
    );
endinterface

interface gasu_out_if
    import gasu_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [PAR_W-1:0] param_value;
    logic [ADDR_W-1:0]       element_position;
    logic                    batch_applied;
    logic                    saturated;
    logic [BATCH_W-1:0]      batches_done;

    modport source (
        output valid, param_value, element_position, batch_applied, saturated,
               batches_done,
        input  ready
    );
    modport sink (
        input  valid, param_value, element_position, batch_applied, saturated,
               batches_done,
        output ready
    );
endinterface

>>> hdl/gasu_div.sv
// ---------------------------------------------------------------------------
// gasu_div
// Restoring divider, one quotient bit per cycle: unsigned MAG_W-bit dividend
// by a WC_W-bit divisor (never zero).
// ---------------------------------------------------------------------------
module gasu_div
    import gasu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MAG_W-1:0] i_dividend,
    input  logic [WC_W-1:0]  i_divisor,
    output logic [MAG_W-1:0] o_quotient,
    output logic             o_done
);
    localparam int CNT_W = $clog2(MAG_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [MAG_W-1:0] r_quo;
    logic [WC_W-1:0]  r_rem;

    logic [WC_W:0]    rem_sh;
    logic [WC_W:0]    div_ext;
    logic             q_bit;
    logic [WC_W:0]    rem_sub;

    assign rem_sh  = {r_rem, r_quo[MAG_W-1]};
    assign div_ext = {1'b0, i_divisor};
    assign q_bit   = (rem_sh >= div_ext);
    assign rem_sub = rem_sh - div_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(MAG_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[MAG_W-2:0], q_bit};
            r_rem <= q_bit ? rem_sub[WC_W-1:0] : rem_sh[WC_W-1:0];
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

>>> hdl/gasu_datapath.sv
// ---------------------------------------------------------------------------
// gasu_datapath
// Accumulator and parameter memories, position/batch counters, sum, divide,
// split multiply, floor shift, clamp and the result register.
// ---------------------------------------------------------------------------
module gasu_datapath
    import gasu_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_status                  o_status,
    input  logic                     i_cfg_we,
    input  logic [WC_W-1:0]          i_cfg_wdata,
    input  logic                     i_kind,
    input  logic signed [GRAD_W-1:0] i_grad_value,
    input  logic [LR_W-1:0]          i_step_rate,
    input  logic [ADDR_W-1:0]        i_read_index,
    output logic signed [PAR_W-1:0]  o_param_value,
    output logic [ADDR_W-1:0]        o_element_position,
    output logic                     o_batch_applied,
    output logic                     o_saturated,
    output logic [BATCH_W-1:0]       o_batches_done
);
    // memories
    logic signed [ACC_W-1:0] mem_acc [VLEN];
    logic signed [PAR_W-1:0] mem_par [VLEN];

    // control state
    logic [WC_W-1:0]    r_wc;
    logic [ADDR_W-1:0]  r_elem;
    logic [MIB_W-1:0]   r_mib;
    logic [BATCH_W-1:0] r_batch;
    logic [ADDR_W-1:0]  r_clr_addr;

    // captured word and working registers
    logic                     r_kind;
    logic                     r_final;
    logic signed [GRAD_W-1:0] r_grad;
    logic [LR_W-1:0]          r_lr;
    logic [ADDR_W-1:0]        r_pos;
    logic signed [ACC_W-1:0]  r_acc_q;
    logic signed [PAR_W-1:0]  r_par_q;
    logic signed [SUM_W-1:0]  r_sum;
    logic [PP_W-1:0]          r_plo;
    logic [PP_W-1:0]          r_phi;
    logic [MAG_W-1:0]         r_qm;
    logic signed [PAR_W-1:0]  r_nv;
    logic                     r_sat;

    // result register
    logic signed [PAR_W-1:0] r_o_param;
    logic [ADDR_W-1:0]       r_o_pos;
    logic                    r_o_applied;
    logic                    r_o_sat;
    logic [BATCH_W-1:0]      r_o_batches;

    logic [WC_W-1:0]         wc_eff;
    logic                    is_final;
    logic [ADDR_W-1:0]       rd_addr;
    logic signed [SUM_W-1:0] neg_sum;
    logic [MAG_W-1:0]        dividend;
    logic [MAG_W-1:0]        quo;
    logic                    div_done;
    logic                    sum_neg;
    logic [PROD_W-1:0]       p_sum;
    logic [PROD_W-1:0]       p_rnd;
    logic signed [NV_W-1:0]  p_ext;
    logic signed [NV_W-1:0]  q_ext;
    logic signed [NV_W-1:0]  nv_full;
    logic                    pos_last;
    logic                    grad_commit;
    logic                    acc_we;
    logic                    par_we;
    logic [ADDR_W-1:0]       wr_addr;
    logic signed [ACC_W-1:0] acc_wdata;
    logic signed [PAR_W-1:0] par_wdata;
    logic [BATCH_W-1:0]      n_batch;
    logic [ADDR_W-1:0]       n_elem;
    logic [MIB_W-1:0]        n_mib;
    logic                    applied;

    // zero means one worker, anything above the max is clamped
    always_comb begin
        priority if (r_wc == '0) begin
            wc_eff = WC_MIN;
        end else if (r_wc > WC_MAX) begin
            wc_eff = WC_MAX;
        end else begin
            wc_eff = r_wc;
        end
    end

    assign is_final = (({1'b0, r_mib} + WC_W'(1)) >= wc_eff);
    assign rd_addr  = i_kind ? i_read_index : r_elem;

    // |sum| for the divider; sign applied after the multiply
    assign sum_neg  = r_sum[SUM_W-1];
    assign neg_sum  = -r_sum;
    assign dividend = sum_neg ? neg_sum[MAG_W-1:0] : r_sum[MAG_W-1:0];

    gasu_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (wc_eff),
        .o_quotient (quo),
        .o_done     (div_done)
    );

    // floor of a negative product = -ceil of its magnitude
    assign p_sum = {{(PROD_W-PP_W){1'b0}}, r_plo}
                 + {r_phi[PROD_W-HALF_W-1:0], {HALF_W{1'b0}}};
    assign p_rnd = p_sum + (sum_neg ? PROD_W'((64'd1 << FRAC_W) - 64'd1) : '0);

    assign p_ext   = NV_W'(r_par_q);
    assign q_ext   = NV_W'({1'b0, r_qm});
    assign nv_full = sum_neg ? (p_ext + q_ext) : (p_ext - q_ext);

    // commit bookkeeping
    assign pos_last    = (r_pos == ADDR_W'(VLEN - 1));
    assign grad_commit = i_cmd.commit && !r_kind;
    assign applied     = r_final && pos_last;

    always_comb begin
        n_batch = r_batch;
        n_elem  = r_elem;
        n_mib   = r_mib;
        if (!r_kind) begin
            n_elem = pos_last ? '0 : r_pos + ADDR_W'(1);
            if (r_final) begin
                if (pos_last) begin
                    n_batch = r_batch + BATCH_W'(1);
                    n_mib   = '0;
                end
            end else if (pos_last) begin
                n_mib = r_mib + MIB_W'(1);
            end
        end
    end

    // memory write port: clearing sweep or commit
    assign wr_addr   = i_cmd.clr_step ? r_clr_addr : r_pos;
    assign acc_we    = i_cmd.clr_step || grad_commit;
    assign par_we    = i_cmd.clr_step || (grad_commit && r_final);
    assign acc_wdata = (i_cmd.clr_step || r_final) ? '0 : r_sum[ACC_W-1:0];
    assign par_wdata = i_cmd.clr_step ? '0 : r_nv;

    always_ff @(posedge i_clk) begin
        if (acc_we) begin
            mem_acc[wr_addr] <= acc_wdata;
        end
        if (i_cmd.capture) begin
            r_acc_q <= mem_acc[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (par_we) begin
            mem_par[wr_addr] <= par_wdata;
        end
        if (i_cmd.capture) begin
            r_par_q <= mem_par[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc       <= WC_RESET;
            r_elem     <= '0;
            r_mib      <= '0;
            r_batch    <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_we) begin
                r_wc <= i_cfg_wdata;
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (grad_commit) begin
                r_elem  <= n_elem;
                r_mib   <= n_mib;
                r_batch <= n_batch;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_kind;
            r_final <= is_final;
            r_grad  <= i_grad_value;
            r_lr    <= i_step_rate;
            r_pos   <= rd_addr;
        end
        if (i_cmd.sum_load) begin
            r_sum <= SUM_W'(r_acc_q) + SUM_W'(r_grad);
        end
        if (i_cmd.mul_lo) begin
            r_plo <= PP_W'(r_lr) * PP_W'(quo[HALF_W-1:0]);
        end
        if (i_cmd.mul_hi) begin
            r_phi <= PP_W'(r_lr) * PP_W'(quo[MAG_W-1:HALF_W]);
        end
        if (i_cmd.round) begin
            r_qm <= p_rnd[PROD_W-1:FRAC_W];
        end
        if (i_cmd.sub) begin
            if (nv_full[NV_W-1:PAR_W-1] == '0 || nv_full[NV_W-1:PAR_W-1] == '1) begin
                r_nv  <= nv_full[PAR_W-1:0];
                r_sat <= 1'b0;
            end else begin
                r_nv  <= nv_full[NV_W-1] ? PAR_MIN : PAR_MAX;
                r_sat <= 1'b1;
            end
        end
        if (i_cmd.commit) begin
            r_o_param   <= (!r_kind && r_final) ? r_nv : r_par_q;
            r_o_pos     <= r_pos;
            r_o_applied <= !r_kind && applied;
            r_o_sat     <= !r_kind && r_final && r_sat;
            r_o_batches <= n_batch;
        end
    end

    assign o_status.kind     = r_kind;
    assign o_status.is_final = r_final;
    assign o_status.div_done = div_done;
    assign o_status.clr_last = (r_clr_addr == ADDR_W'(VLEN - 1));

    assign o_param_value      = r_o_param;
    assign o_element_position = r_o_pos;
    assign o_batch_applied    = r_o_applied;
    assign o_saturated        = r_o_sat;
    assign o_batches_done     = r_o_batches;

endmodule

>>> hdl/gasu_ctrl.sv
// ---------------------------------------------------------------------------
// gasu_ctrl
// Sequencer: clearing sweep, word capture, divide/multiply steps, and the
// output-register valid.
// ---------------------------------------------------------------------------
module gasu_ctrl
    import gasu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = (!i_status.kind && i_status.is_final) ? ST_DIV_START : ST_FIN;
            end
            ST_DIV_START: n_state = ST_DIV;
            ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = ST_MUL_LO;
                end
            end
            ST_MUL_LO: n_state = ST_MUL_HI;
            ST_MUL_HI: n_state = ST_ROUND;
            ST_ROUND:  n_state = ST_SUB;
            ST_SUB:    n_state = ST_FIN;
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_in_ready      = 1'b0;
        o_cmd.clr_step  = (r_state == ST_CLEAR);
        o_in_ready      = (r_state == ST_IDLE);
        o_cmd.capture   = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.sum_load  = (r_state == ST_READ);
        o_cmd.div_start = (r_state == ST_DIV_START);
        o_cmd.mul_lo    = (r_state == ST_MUL_LO);
        o_cmd.mul_hi    = (r_state == ST_MUL_HI);
        o_cmd.round     = (r_state == ST_ROUND);
        o_cmd.sub       = (r_state == ST_SUB);
        o_cmd.commit    = (r_state == ST_FIN) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> hdl/gradient_average_sgd_update_core.sv
// ---------------------------------------------------------------------------
// gradient_average_sgd_update_core
// SGD parameter server with gradient averaging over a batch of workers,
// Q8.24 parameters, 512-element vectors.
// ---------------------------------------------------------------------------
// Usage: gradient words (kind 0) arrive in element order; an internal
// position counter tags each one. Every message but the last of a batch
// adds its element into that position's 40-bit accumulator. On the batch's
// last message (worker_count messages, clamped to 1..64) each element
// computes avg = (acc + g) / worker_count truncated toward zero, then
// param -= (lr * avg) >> 24 (floor), clamped to 32 bits, and clears the
// accumulator. Read words (kind 1) return the parameter at read_index and
// change nothing. One result word per input word, in order.
// Sequence: after reset the core zeroes both memories (one entry per
// cycle) and accepts no words meanwhile; worker_count writes are taken at
// any time. A read word or a non-final gradient word passes through
// capture with memory read, sum and commit. A final gradient word also
// runs the radix-2 divider over the 40-bit magnitude, two split multiply
// steps, rounding and clamp before its commit. The result sits in an
// output register, so the next word is accepted while the last result
// waits; a commit waits only when that register is still full.
// ---------------------------------------------------------------------------
module gradient_average_sgd_update_core
    import gasu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [WC_W-1:0]   i_cfg_wdata,
    gasu_in_if.sink           i_grad,
    gasu_out_if.source        o_result
);
    t_cmd    cmd;
    t_status status;

    // sequencer: owns the state and the result valid
    gasu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_grad.valid),
        .o_in_ready  (i_grad.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // memories, arithmetic and the result payload
    gasu_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_kind             (i_grad.kind),
        .i_grad_value       (i_grad.grad_value),
        .i_step_rate        (i_grad.step_rate),
        .i_read_index       (i_grad.read_index),
        .o_param_value      (o_result.param_value),
        .o_element_position (o_result.element_position),
        .o_batch_applied    (o_result.batch_applied),
        .o_saturated        (o_result.saturated),
        .o_batches_done     (o_result.batches_done)
    );

endmodule

>>> hdl/gasu_checker.sv
// ---------------------------------------------------------------------------
// gasu_checker
// Port-level checks on the update core: reset, result count, batch_applied position, batch count and stall hold.
// ---------------------------------------------------------------------------
module gasu_checker
    import gasu_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [ADDR_W-1:0]  i_out_pos,
    input logic               i_out_applied,
    input logic [BATCH_W-1:0] i_out_batches
);
    logic               in_acc;
    logic               out_acc;
    logic [1:0]         r_pending;
    logic [BATCH_W-1:0] r_last_batches;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending      <= '0;
            r_last_batches <= '0;
        end else begin
            r_pending <= r_pending + 2'(in_acc) - 2'(out_acc);
            if (out_acc) begin
                r_last_batches <= i_out_batches;
            end
        end
    end

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_no_extra_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> r_pending != 2'd0)
        else $error("result word without an accepted input word");

    a_applied_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_applied) |-> i_out_pos == ADDR_W'(VLEN - 1))
        else $error("batch applied away from the last element");

    a_batch_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> i_out_batches == r_last_batches + BATCH_W'(i_out_applied))
        else $error("batch count out of step with batch_applied");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

endmodule

bind gradient_average_sgd_update_core gasu_checker u_gasu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_grad.valid),
    .i_in_ready    (i_grad.ready),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_out_pos     (o_result.element_position),
    .i_out_applied (o_result.batch_applied),
    .i_out_batches (o_result.batches_done)
);
